[design/wmd_pkg.sv]
// Package for the window minimizer block: sizes, reset values, controller
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int HASH_BITS  = 38;
    localparam int WS_W       = 6;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam logic [WS_W-1:0]      WS_RESET   = WS_W'(16);
    localparam logic [HASH_BITS-1:0] HASH_ONES  = {HASH_BITS{1'b1}};
    localparam logic [HASH_BITS-1:0] HASH_ZERO  = '0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic prime_wr;   // store a priming value
        logic seq_wr;     // store a window value and start a scan
        logic end_seq;    // build the end marker and restart the sequence
        logic scan_rd;    // read one window entry
        logic cmp;        // compare the window minimum with the last one sent
        logic load_out;   // move the pending result into the output register
    } wmd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic priming;
        logic hash_zero;
        logic scan_last;
        logic min_new;
        logic out_free;
    } wmd_status_t;

endpackage

`default_nettype wire

[design/wmd_ctrl.sv]
// Controller state machine of the window minimizer.
// Depends on wmd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module wmd_ctrl
    import wmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wmd_status_t      status,
    output wmd_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status.priming) begin
                        cmd.prime_wr = 1'b1;
                    end else if (status.hash_zero) begin
                        cmd.end_seq = 1'b1;
                        state_next  = ST_EMIT;
                    end else begin
                        cmd.seq_wr = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            // The read data of the last entry is folded in during this cycle.
            ST_LAST: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = status.min_new ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/wmd_dpath.sv]
// Datapath of the window minimizer: window store, position and priming
// counters, running minimum, result and output registers. Depends on wmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmd_dpath
    import wmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [WS_W-1:0]      cfg_wdata,
    input  wire logic [HASH_BITS-1:0] s_hash_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [HASH_BITS-1:0]      m_minimizer,
    output logic                      m_end_of_sequence,
    input  wmd_cmd_t                  cmd,
    output wmd_status_t               status
);

    logic [HASH_BITS-1:0] store_mem [MAX_WINDOW];

    logic [WS_W-1:0]      ws_reg;
    logic [ADDR_W-1:0]    pos_reg;
    logic [CNT_W-1:0]     prime_reg;
    logic [HASH_BITS-1:0] last_reg;
    logic [HASH_BITS-1:0] min_reg;
    logic [HASH_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    scan_cnt_reg;
    logic [HASH_BITS-1:0] res_min_reg;
    logic                 res_eos_reg;
    logic [HASH_BITS-1:0] out_min_reg;
    logic                 out_eos_reg;
    logic                 out_vld_reg;

    logic [CNT_W-1:0]     w_eff;
    logic [CNT_W-1:0]     w_m1_full;
    logic [ADDR_W-1:0]    w_m1;
    logic [ADDR_W-1:0]    seq_idx;
    logic [ADDR_W-1:0]    wr_idx;
    logic                 wr_en;

    // Window sizes below two act as two, above the store depth as the depth.
    always_comb begin
        if (int'(ws_reg) < 2) begin
            w_eff = CNT_W'(2);
        end else if (int'(ws_reg) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(ws_reg);
        end
    end

    assign w_m1_full = w_eff - CNT_W'(1);
    assign w_m1      = w_m1_full[ADDR_W-1:0];
    // The new value is written just behind pos_reg, wrapping to the last window entry.
    assign seq_idx   = (pos_reg == '0) ? w_m1 : pos_reg - ADDR_W'(1);
    assign wr_idx    = cmd.prime_wr ? prime_reg[ADDR_W-1:0] : seq_idx;
    assign wr_en     = cmd.prime_wr | cmd.seq_wr;

    assign status.priming   = prime_reg < w_m1_full;
    assign status.hash_zero = s_hash_value == HASH_ZERO;
    assign status.scan_last = scan_cnt_reg == w_m1;
    assign status.min_new   = min_reg != last_reg;
    assign status.out_free  = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_idx] <= s_hash_value;
        end
        if (cmd.scan_rd) begin
            rd_data_reg <= store_mem[scan_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seq_wr) begin
            min_reg <= HASH_ONES;
        end else if (rd_vld_reg && (rd_data_reg < min_reg)) begin
            min_reg <= rd_data_reg;
        end
        if (cmd.end_seq) begin
            res_min_reg <= HASH_ZERO;
            res_eos_reg <= 1'b1;
        end else if (cmd.cmp) begin
            res_min_reg <= min_reg;
            res_eos_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_min_reg <= res_min_reg;
            out_eos_reg <= res_eos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg       <= WS_RESET;
            pos_reg      <= '0;
            prime_reg    <= '0;
            last_reg     <= HASH_ONES;
            rd_vld_reg   <= 1'b0;
            scan_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                ws_reg    <= cfg_wdata;
                pos_reg   <= '0;
                prime_reg <= '0;
                last_reg  <= HASH_ONES;
            end else if (cmd.end_seq) begin
                pos_reg   <= '0;
                prime_reg <= '0;
                last_reg  <= HASH_ONES;
            end else begin
                if (cmd.prime_wr) begin
                    prime_reg <= prime_reg + CNT_W'(1);
                end
                if (cmd.seq_wr) begin
                    pos_reg <= (pos_reg == w_m1) ? '0 : pos_reg + ADDR_W'(1);
                end
                if (cmd.cmp && status.min_new) begin
                    last_reg <= min_reg;
                end
            end
            if (cmd.seq_wr) begin
                scan_cnt_reg <= '0;
            end else if (cmd.scan_rd) begin
                scan_cnt_reg <= scan_cnt_reg + ADDR_W'(1);
            end
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_minimizer       = out_min_reg;
    assign m_end_of_sequence = out_eos_reg;

endmodule

`default_nettype wire

[design/window_minimizer_dedup.sv]
// Top level of the sliding-window minimizer with repeat suppression.
// Depends on wmd_pkg, wmd_ctrl and wmd_dpath.
//
// Usage: hash values arrive on the s_ channel (valid/ready), results leave
// on the m_ channel (valid/ready). A transfer takes place when valid and
// ready are both high at a rising edge of aclk. cfg_we writes the window
// size (reset 16, clamped to 2..32) and restarts the sequence.
// The first window_size-1 values of a sequence fill the store, one per cycle.
// After that, a nonzero value is written into the store and the window is
// scanned through the store's single read port, one entry per cycle; the
// block takes no new value until the scan, the fold of the last entry, the
// compare and, for a new minimum, its load into the output register are
// done. A zero after priming produces the end marker, and the block is
// ready again once it is in the output register. The output register holds
// one result; while the receiver stalls, the block keeps accepting values
// until it has a further result to place. Reset (aresetn low, synchronous)
// empties the output register, sets the window size to 16 and returns to
// the priming state.
`timescale 1ns / 1ps
`default_nettype none

module window_minimizer_dedup
    import wmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [WS_W-1:0]      cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [HASH_BITS-1:0] s_hash_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [HASH_BITS-1:0]      m_minimizer,
    output logic                      m_end_of_sequence
);

    wmd_cmd_t    cmd;
    wmd_status_t status;

    wmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wmd_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_hash_value      (s_hash_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_minimizer       (m_minimizer),
        .m_end_of_sequence (m_end_of_sequence),
        .cmd               (cmd),
        .status            (status)
    );

    // The end marker always carries a zero minimizer.
    a_eos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_sequence) |-> (m_minimizer == '0))
        else $error("end marker with nonzero minimizer");

    // No input transfer is taken while the window is being scanned.
    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> !s_ready)
        else $error("input ready during window scan");

    // A result is only loaded when the output register is free.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");

    // A scan step follows every window write.
    a_scan_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seq_wr |=> cmd.scan_rd)
        else $error("window write not followed by scan");

endmodule

`default_nettype wire
